[rtl/mjpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-joint PD effort controller package
// Shared codes, the joint table entry and the update handoff type.
// ----------------------------------------------------------------------------
package mjpd_pkg;

  localparam int NUM_JOINTS_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_CMD    = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] SEL_KP      = 3'd0;
  localparam logic [2:0] SEL_KD      = 3'd1;
  localparam logic [2:0] SEL_MODE    = 3'd2;
  localparam logic [2:0] SEL_POS_LO  = 3'd3;
  localparam logic [2:0] SEL_POS_HI  = 3'd4;
  localparam logic [2:0] SEL_EFF_LO  = 3'd5;
  localparam logic [2:0] SEL_EFF_HI  = 3'd6;

  localparam logic [1:0] MODE_POSITION = 2'd0;
  localparam logic [1:0] MODE_VELOCITY = 2'd1;
  localparam logic [1:0] MODE_TORQUE   = 2'd2;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic        [1:0]  mode;
    logic signed [15:0] pos_lo;
    logic signed [15:0] pos_hi;
    logic signed [15:0] eff_lo;
    logic signed [15:0] eff_hi;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    setpoint: 16'sh0000,
    kp:       16'sh0000,
    kd:       16'sh0000,
    mode:     MODE_POSITION,
    pos_lo:   16'sh8000,
    pos_hi:   16'sh7FFF,
    eff_lo:   16'sh8000,
    eff_hi:   16'sh7FFF
  };

  typedef struct packed {
    logic        [3:0]  joint;
    logic               torque;
    logic signed [15:0] setpoint;
    logic signed [15:0] kp;
    logic signed [16:0] p_opnd;
    logic signed [15:0] kd_opnd;
    logic signed [15:0] vel;
    logic signed [15:0] eff_lo;
    logic signed [15:0] eff_hi;
  } upd_t;

endpackage
`default_nettype wire

[rtl/multi_joint_pd_effort_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-joint PD effort controller
// Per-joint gains, mode, limits and setpoint held in one table; update
// beats give a saturated, limit-clamped effort per joint.
//
//   Channel | Direction | Handshake             | Fields
//   in      | input     | in_valid / in_ready   | action, joint, param_select,
//           |           |                       | value, measured_position,
//           |           |                       | measured_velocity
//   out     | output    | out_valid / out_ready | out_joint, effort, limited
//
// One input beat per cycle while in_ready is high; an update beat passes
// through the table read, the product stage, the scaling stage and the
// output register. Load and command beats finish in the table stage.
// Reset clears all pipeline valids and marks every joint entry unwritten,
// so it reads as its default values. An output stall fills the pipeline
// bubbles before in_ready drops.
// ----------------------------------------------------------------------------
module multi_joint_pd_effort_controller_top #(
  parameter int NUM_JOINTS     = mjpd_pkg::NUM_JOINTS_DEF,
  parameter int GAIN_FRAC_BITS = mjpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [3:0]         joint,
  input  wire logic [2:0]         param_select,
  input  wire logic signed [15:0] value,
  input  wire logic signed [15:0] measured_position,
  input  wire logic signed [15:0] measured_velocity,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_joint,
  output logic signed [15:0]      effort,
  output logic                    limited
);

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  logic               accept;
  logic               in_range;
  logic               v1;
  logic [1:0]         act1;
  logic [3:0]         joint1;
  logic [2:0]         sel1;
  logic signed [15:0] val1, pos1, vel1;
  logic               s1_leave;
  logic               up_ready;
  logic               wr_en;

  mjpd_pkg::entry_t   cur, nxt;
  mjpd_pkg::upd_t     upd;

  logic               torque, vel_mode;
  logic signed [15:0] cmd_raise, cmd_clamp;
  logic signed [15:0] perr;
  logic signed [16:0] vdiff;

  assign accept   = in_valid && in_ready;
  assign in_range = ({28'd0, joint} < 32'(NUM_JOINTS));
  assign s1_leave = v1 && ((act1 != mjpd_pkg::ACT_UPDATE) || up_ready);
  assign in_ready = !v1 || s1_leave;
  assign wr_en    = v1 && (act1 != mjpd_pkg::ACT_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid && in_range && (action != mjpd_pkg::ACT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act1   <= action;
      joint1 <= joint;
      sel1   <= param_select;
      val1   <= value;
      pos1   <= measured_position;
      vel1   <= measured_velocity;
    end
  end

  mjpd_table #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (AW'(joint)),
    .wr_en   (wr_en),
    .wr_addr (AW'(joint1)),
    .wr_data (nxt),
    .rd_entry(cur)
  );

  assign torque   = (cur.mode == mjpd_pkg::MODE_TORQUE);
  assign vel_mode = (cur.mode == mjpd_pkg::MODE_VELOCITY);

  always_comb begin
    cmd_raise = (val1 < cur.pos_lo) ? cur.pos_lo : val1;
    cmd_clamp = (cmd_raise > cur.pos_hi) ? cur.pos_hi : cmd_raise;
  end

  always_comb begin
    nxt = cur;
    unique case (act1)
      mjpd_pkg::ACT_LOAD: begin
        unique case (sel1)
          mjpd_pkg::SEL_KP:     nxt.kp     = val1;
          mjpd_pkg::SEL_KD:     nxt.kd     = val1;
          mjpd_pkg::SEL_MODE:   nxt.mode   = val1[1:0];
          mjpd_pkg::SEL_POS_LO: nxt.pos_lo = val1;
          mjpd_pkg::SEL_POS_HI: nxt.pos_hi = val1;
          mjpd_pkg::SEL_EFF_LO: nxt.eff_lo = val1;
          mjpd_pkg::SEL_EFF_HI: nxt.eff_hi = val1;
          default: ;
        endcase
      end
      mjpd_pkg::ACT_CMD: begin
        nxt.setpoint = torque ? val1 : cmd_clamp;
      end
      default: ;
    endcase
  end

  always_comb begin
    perr  = cur.setpoint - pos1;
    vdiff = {cur.setpoint[15], cur.setpoint} - {vel1[15], vel1};
    upd.joint    = joint1;
    upd.torque   = torque;
    upd.setpoint = cur.setpoint;
    upd.kp       = cur.kp;
    upd.p_opnd   = vel_mode ? vdiff : {perr[15], perr};
    upd.kd_opnd  = vel_mode ? 16'sh0000 : cur.kd;
    upd.vel      = vel1;
    upd.eff_lo   = cur.eff_lo;
    upd.eff_hi   = cur.eff_hi;
  end

  mjpd_effort #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_effort (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v1 && (act1 == mjpd_pkg::ACT_UPDATE)),
    .up_ready (up_ready),
    .upd      (upd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_joint(out_joint),
    .effort   (effort),
    .limited  (limited)
  );

endmodule
`default_nettype wire

[rtl/mjpd_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Joint parameter table
// Synchronous memory of joint entries with per-entry written bits
// and forwarding of the most recent write.
// ----------------------------------------------------------------------------
module mjpd_table #(
  parameter int NUM_JOINTS = mjpd_pkg::NUM_JOINTS_DEF,
  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire mjpd_pkg::entry_t wr_data,
  output mjpd_pkg::entry_t      rd_entry
);

  mjpd_pkg::entry_t mem [NUM_JOINTS];
  mjpd_pkg::entry_t rd_data;
  mjpd_pkg::entry_t fwd_data;
  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    fwd_addr;
  logic             fwd_valid;
  logic [NUM_JOINTS-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      fwd_data <= wr_data;
      fwd_addr <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
      fwd_valid        <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr_q)) begin
      rd_entry = fwd_data;
    end else if (written[rd_addr_q]) begin
      rd_entry = rd_data;
    end else begin
      rd_entry = mjpd_pkg::ENTRY_RESET;
    end
  end

endmodule
`default_nettype wire

[rtl/mjpd_effort.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Effort pipeline
// Gain products, fixed-point scaling with 16-bit saturation or the torque
// setpoint, effort limit clamp and the output register.
// ----------------------------------------------------------------------------
module mjpd_effort #(
  parameter int GAIN_FRAC_BITS = mjpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire mjpd_pkg::upd_t  upd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           out_joint,
  output logic signed [15:0]   effort,
  output logic                 limited
);

  logic en_o, en3, en2;
  logic v2, v3;

  logic signed [32:0] prod_p;
  logic signed [31:0] prod_d;

  logic [3:0]         joint2;
  logic               torque2;
  logic signed [15:0] set2;
  logic signed [32:0] prod_p2;
  logic signed [31:0] prod_d2;
  logic signed [15:0] lo2, hi2;

  logic signed [33:0] sum;
  logic signed [33:0] shifted;
  logic signed [15:0] sat_c;
  logic               sat_lim_c;

  logic [3:0]         joint3;
  logic signed [15:0] sat3;
  logic               lim3;
  logic signed [15:0] lo3, hi3;

  logic signed [15:0] raise_c, eff_c;

  assign en_o     = !out_valid || out_ready;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign up_ready = en2;

  assign prod_p = upd.p_opnd * upd.kp;
  assign prod_d = upd.kd_opnd * upd.vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) begin
        v2 <= up_valid;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_o) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && up_valid) begin
      joint2  <= upd.joint;
      torque2 <= upd.torque;
      set2    <= upd.setpoint;
      prod_p2 <= prod_p;
      prod_d2 <= prod_d;
      lo2     <= upd.eff_lo;
      hi2     <= upd.eff_hi;
    end
  end

  always_comb begin
    sum       = prod_p2 - prod_d2;
    shifted   = sum >>> GAIN_FRAC_BITS;
    sat_lim_c = 1'b0;
    if (torque2) begin
      sat_c = set2;
    end else if (shifted > 34'sd32767) begin
      sat_c     = 16'sh7FFF;
      sat_lim_c = 1'b1;
    end else if (shifted < -34'sd32768) begin
      sat_c     = 16'sh8000;
      sat_lim_c = 1'b1;
    end else begin
      sat_c = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      joint3 <= joint2;
      sat3   <= sat_c;
      lim3   <= sat_lim_c;
      lo3    <= lo2;
      hi3    <= hi2;
    end
  end

  always_comb begin
    raise_c = (sat3 < lo3) ? lo3 : sat3;
    eff_c   = (raise_c > hi3) ? hi3 : raise_c;
  end

  always_ff @(posedge clk) begin
    if (en_o && v3) begin
      out_joint <= joint3;
      effort    <= eff_c;
      limited   <= lim3 || (eff_c != sat3);
    end
  end

endmodule
`default_nettype wire

[sim/tb_multi_joint_pd_effort_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-joint PD effort controller testbench
// Directed and random load, command and update beats are driven through the
// input channel in random bursts. Each update beat is predicted by a joint
// table model of the controller and checked against the effort beats taken
// from the output channel, which stalls on its own pattern and once holds
// off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_multi_joint_pd_effort_controller_top;

  localparam int NJ        = mjpd_pkg::NUM_JOINTS_DEF;
  localparam int FRAC      = mjpd_pkg::GAIN_FRAC_BITS_DEF;
  localparam int LIVE_GOAL = 950;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 250;
  localparam int LIMIT     = 200000;

  typedef struct packed {
    logic [1:0]         act;
    logic [3:0]         jnt;
    logic [2:0]         sel;
    logic signed [15:0] val;
    logic signed [15:0] pos;
    logic signed [15:0] vel;
  } ctrl_beat_t;

  typedef struct packed {
    logic [3:0]         jnt;
    logic signed [15:0] eff;
    logic               lim;
  } effort_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = mjpd_pkg::ACT_NONE;
  logic [3:0]         joint = '0;
  logic [2:0]         param_select = '0;
  logic signed [15:0] value = '0;
  logic signed [15:0] measured_position = '0;
  logic signed [15:0] measured_velocity = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_joint;
  logic signed [15:0] effort;
  logic               limited;

  ctrl_beat_t   pending_q[$];
  effort_beat_t effort_q[$];
  ctrl_beat_t   drv_beat;
  bit           in_taken = 1'b0;
  bit           hold_rx = 1'b0;
  int           mismatches = 0;
  int           accepted = 0;
  int           stim_live = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           rx_style = 0;
  int           rx_seg_left = 0;
  int           rx_phase = 0;

  logic signed [15:0] sp_tab[NJ];
  logic signed [15:0] kp_tab[NJ];
  logic signed [15:0] kd_tab[NJ];
  logic [1:0]         mode_tab[NJ];
  logic signed [15:0] plo_tab[NJ];
  logic signed [15:0] phi_tab[NJ];
  logic signed [15:0] elo_tab[NJ];
  logic signed [15:0] ehi_tab[NJ];

  multi_joint_pd_effort_controller_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .joint(joint),
    .param_select(param_select),
    .value(value),
    .measured_position(measured_position),
    .measured_velocity(measured_velocity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_joint(out_joint),
    .effort(effort),
    .limited(limited)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_joints();
    for (int k = 0; k < NJ; k++) begin
      sp_tab[k]   = 16'sh0000;
      kp_tab[k]   = 16'sh0000;
      kd_tab[k]   = 16'sh0000;
      mode_tab[k] = mjpd_pkg::MODE_POSITION;
      plo_tab[k]  = 16'sh8000;
      phi_tab[k]  = 16'sh7FFF;
      elo_tab[k]  = 16'sh8000;
      ehi_tab[k]  = 16'sh7FFF;
    end
  endtask

  function automatic int clamp_to(input int v, input int lo, input int hi);
    int r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  task automatic predict_effort(input ctrl_beat_t b);
    logic signed [15:0] err;
    longint             raw;
    int                 sat;
    int                 eff;
    bit                 lim;
    effort_beat_t       res;
    int                 j;
    j = int'(b.jnt);
    if (j >= NJ) return;
    case (b.act)
      mjpd_pkg::ACT_LOAD: begin
        case (b.sel)
          mjpd_pkg::SEL_KP:     kp_tab[j] = b.val;
          mjpd_pkg::SEL_KD:     kd_tab[j] = b.val;
          mjpd_pkg::SEL_MODE:   mode_tab[j] = b.val[1:0];
          mjpd_pkg::SEL_POS_LO: plo_tab[j] = b.val;
          mjpd_pkg::SEL_POS_HI: phi_tab[j] = b.val;
          mjpd_pkg::SEL_EFF_LO: elo_tab[j] = b.val;
          mjpd_pkg::SEL_EFF_HI: ehi_tab[j] = b.val;
          default: ;
        endcase
      end
      mjpd_pkg::ACT_CMD: begin
        if (mode_tab[j] == mjpd_pkg::MODE_TORQUE) begin
          sp_tab[j] = b.val;
        end else begin
          sp_tab[j] = 16'(clamp_to(int'(b.val), int'(plo_tab[j]), int'(phi_tab[j])));
        end
      end
      mjpd_pkg::ACT_UPDATE: begin
        lim = 1'b0;
        if (mode_tab[j] == mjpd_pkg::MODE_TORQUE) begin
          raw = longint'(sp_tab[j]);
        end else if (mode_tab[j] == mjpd_pkg::MODE_VELOCITY) begin
          raw = (longint'(kp_tab[j]) * (longint'(sp_tab[j]) - longint'(b.vel))) >>> FRAC;
        end else begin
          err = sp_tab[j] - b.pos;
          raw = (longint'(kp_tab[j]) * longint'(err)
                 - longint'(kd_tab[j]) * longint'(b.vel)) >>> FRAC;
        end
        if (raw > 32767) begin
          sat = 32767;
          lim = 1'b1;
        end else if (raw < -32768) begin
          sat = -32768;
          lim = 1'b1;
        end else begin
          sat = int'(raw);
        end
        eff = clamp_to(sat, int'(elo_tab[j]), int'(ehi_tab[j]));
        if (eff != sat) lim = 1'b1;
        res.jnt = b.jnt;
        res.eff = 16'(eff);
        res.lim = lim;
        effort_q.insert(effort_q.size(), res);
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [1:0] act, input logic [3:0] jnt, input logic [2:0] sel,
                          input logic signed [15:0] val, input logic signed [15:0] pos,
                          input logic signed [15:0] vel);
    ctrl_beat_t b;
    b.act = act;
    b.jnt = jnt;
    b.sel = sel;
    b.val = val;
    b.pos = pos;
    b.vel = vel;
    pending_q.insert(pending_q.size(), b);
    if (act != mjpd_pkg::ACT_NONE &&
        !(act == mjpd_pkg::ACT_LOAD && sel > mjpd_pkg::SEL_EFF_HI)) stim_live++;
  endtask

  function automatic logic signed [15:0] rand_word();
    int t;
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    t = int'($urandom_range(0, 1200)) - 600;
    return 16'(t);
  endfunction

  function automatic logic signed [15:0] rand_gain();
    int t;
    if ($urandom_range(0, 9) < 3) return 16'($urandom);
    t = int'($urandom_range(0, 4096)) - 2048;
    return 16'(t);
  endfunction

  task automatic add_joint_setup(input logic [3:0] j);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    int                 n;
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_MODE, 16'($urandom), '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_KP, rand_gain(), '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_KD, rand_gain(), '0, '0);
    if ($urandom_range(0, 1) == 0) begin
      lo = 16'sh8000;
      hi = 16'sh7FFF;
    end else begin
      lo = rand_word();
      hi = rand_word();
    end
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_POS_LO, lo, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_POS_HI, hi, '0, '0);
    if ($urandom_range(0, 2) == 0) begin
      lo = rand_word();
      hi = rand_word();
    end else begin
      lo = 16'sh8000;
      hi = 16'sh7FFF;
    end
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_EFF_LO, lo, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, j, mjpd_pkg::SEL_EFF_HI, hi, '0, '0);
    add_item(mjpd_pkg::ACT_CMD, j, 3'($urandom), rand_word(), 16'($urandom), 16'($urandom));
    n = $urandom_range(2, 6);
    for (int k = 0; k < n; k++) begin
      add_item(mjpd_pkg::ACT_UPDATE, j, 3'($urandom), 16'($urandom), rand_word(), rand_word());
    end
  endtask

  task automatic build_stimulus();
    int          r;
    logic [3:0]  j;
    // Full gains and extreme angles drive the sum into saturation.
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, mjpd_pkg::SEL_KP, 16'sh7FFF, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, mjpd_pkg::SEL_KD, 16'sh8000, '0, '0);
    add_item(mjpd_pkg::ACT_CMD, 4'd1, mjpd_pkg::SEL_KP, 16'sh7FFF, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd1, mjpd_pkg::SEL_KP, '0, 16'sh8000, 16'sh7FFF);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd1, mjpd_pkg::SEL_KP, '0, 16'sh0000, 16'sh8000);
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, mjpd_pkg::SEL_EFF_LO, -16'sd100, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, mjpd_pkg::SEL_EFF_HI, 16'sd100, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd1, mjpd_pkg::SEL_KP, '0, 16'sh8000, 16'sh7FFF);
    // Crossed position and effort limits settle on the high bound.
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_POS_LO, 16'sd500, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_POS_HI, -16'sd500, '0, '0);
    add_item(mjpd_pkg::ACT_CMD, 4'd2, mjpd_pkg::SEL_KP, 16'sd0, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_KP, 16'sh0100, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd2, mjpd_pkg::SEL_KP, '0, 16'sd0, 16'sd0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_EFF_LO, 16'sd50, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_EFF_HI, -16'sd50, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd2, mjpd_pkg::SEL_KP, '0, 16'sd0, 16'sd0);
    // Velocity mode at the edge of the range.
    add_item(mjpd_pkg::ACT_LOAD, 4'd3, mjpd_pkg::SEL_MODE, 16'(mjpd_pkg::MODE_VELOCITY),
             '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd3, mjpd_pkg::SEL_KP, 16'sh0080, '0, '0);
    add_item(mjpd_pkg::ACT_CMD, 4'd3, mjpd_pkg::SEL_KP, 16'sh8000, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd3, mjpd_pkg::SEL_KP, '0, '0, 16'sh7FFF);
    // Torque mode: only the low mode bits count and the setpoint is not clamped.
    add_item(mjpd_pkg::ACT_LOAD, 4'd4, mjpd_pkg::SEL_MODE, 16'shFFF6, '0, '0);
    add_item(mjpd_pkg::ACT_CMD, 4'd4, mjpd_pkg::SEL_KP, 16'sh7FFF, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd4, mjpd_pkg::SEL_KP, '0, '0, '0);
    // A mode change keeps the clamped setpoint, and mode three acts as position.
    add_item(mjpd_pkg::ACT_LOAD, 4'd2, mjpd_pkg::SEL_MODE, 16'(mjpd_pkg::MODE_TORQUE),
             '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd2, mjpd_pkg::SEL_KP, '0, '0, '0);
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, mjpd_pkg::SEL_MODE, 16'shFFFF, '0, '0);
    add_item(mjpd_pkg::ACT_UPDATE, 4'd1, mjpd_pkg::SEL_KP, '0, 16'sh8000, 16'sh7FFF);
    add_item(mjpd_pkg::ACT_NONE, 4'd1, mjpd_pkg::SEL_KP, 16'sh1234, 16'sh1234, 16'sh1234);
    add_item(mjpd_pkg::ACT_LOAD, 4'd1, 3'd7, 16'sh0000, '0, '0);

    while (stim_live < LIVE_GOAL) begin
      j = 4'($urandom);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_joint_setup(j);
      end else if (r < 18) begin
        if ($urandom_range(0, 1) == 0) begin
          add_item(mjpd_pkg::ACT_NONE, j, 3'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
        end else begin
          add_item(mjpd_pkg::ACT_LOAD, j, 3'd7, 16'($urandom), 16'($urandom), 16'($urandom));
        end
      end else if (r < 32) begin
        add_item(mjpd_pkg::ACT_LOAD, j, 3'($urandom_range(0, 6)), rand_word(), 16'($urandom),
                 16'($urandom));
      end else if (r < 45) begin
        add_item(mjpd_pkg::ACT_CMD, j, 3'($urandom), rand_word(), 16'($urandom),
                 16'($urandom));
      end else begin
        add_item(mjpd_pkg::ACT_UPDATE, j, 3'($urandom), 16'($urandom), rand_word(),
                 rand_word());
      end
    end
  endtask

  // Input side: bursts of beats separated by idle gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        drv_beat = pending_q.pop_front();
        action <= drv_beat.act;
        joint <= drv_beat.jnt;
        param_select <= drv_beat.sel;
        value <= drv_beat.val;
        measured_position <= drv_beat.pos;
        measured_velocity <= drv_beat.vel;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: stall style changes from one stretch to the next.
  always @(negedge clk) begin
    bit rdy;
    if (rx_seg_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_seg_left = $urandom_range(20, 200);
    end else begin
      rx_seg_left--;
    end
    rx_phase++;
    case (rx_style)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = (rx_phase % 4 == 0);
      default: rdy = ($urandom_range(0, 4) == 0);
    endcase
    out_ready <= rdy && !hold_rx;
  end

  initial begin
    while (accepted < HOLD_AT) @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin
    effort_beat_t want;
    if (rst) begin
      clear_joints();
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        accepted++;
        predict_effort(drv_beat);
      end
      if (out_valid && out_ready) begin
        if (effort_q.size() == 0) begin
          report_mismatch($sformatf("unexpected effort beat joint %0d effort %0d limited %0b",
                                    out_joint, effort, limited));
        end else begin
          want = effort_q.pop_front();
          if (out_joint !== want.jnt)
            report_mismatch($sformatf("out_joint %0d, predicted %0d", out_joint, want.jnt));
          if (effort !== want.eff)
            report_mismatch($sformatf("joint %0d effort %0d, predicted %0d",
                                      want.jnt, effort, want.eff));
          if (limited !== want.lim)
            report_mismatch($sformatf("joint %0d limited %0b, predicted %0b",
                                      want.jnt, limited, want.lim));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("** multi_joint_pd_effort_controller_top: FAILED **");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (effort_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** multi_joint_pd_effort_controller_top: PASSED **");
    end else begin
      $display("** multi_joint_pd_effort_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
